[rtl/core/tfcb_pkg.sv]
package tfcb_pkg;

  // Register map: one register per 32-bit word
  localparam int unsigned REG_COUNT  = 2;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned MAX_BYTES  = 7;
  localparam int unsigned CNT_W      = 3;

  typedef enum logic {
    REG_HEADER = 1'b0,
    REG_DEST   = 1'b1
  } reg_sel_t;

  localparam logic [7:0] HEADER_RST = 8'hAA;
  localparam logic [7:0] DEST_RST   = 8'hFF;

  typedef logic [7:0] byte_t;

  // One accepted input beat as held ahead of the framing logic
  typedef struct packed {
    byte_t payload_byte;
    logic  frame_start;
    byte_t function_code;
    byte_t payload_length;
  } in_beat_t;

  // Running frame state
  typedef struct packed {
    byte_t byte_sum;
    byte_t sum_of_sums;
    byte_t bytes_left;
  } frame_state_t;

  // Bytes produced by one input beat plus the updated frame state
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      closes;
    frame_state_t              state;
  } frame_res_t;

endpackage

[rtl/core/tfcb_frame_calc.sv]
module tfcb_frame_calc (
  input  tfcb_pkg::in_beat_t     beat,
  input  tfcb_pkg::frame_state_t cur,
  input  tfcb_pkg::byte_t        header_byte,
  input  tfcb_pkg::byte_t        dest_address,
  output tfcb_pkg::frame_res_t   res
);
  import tfcb_pkg::*;

  byte_t s1;
  byte_t s2;
  byte_t left_base;
  byte_t left_new;
  logic  active;

  always_comb begin
    res    = '0;
    active = beat.frame_start || (cur.bytes_left != 8'd0);

    // Fresh sums on a start, then count the four header bytes
    if (beat.frame_start) begin
      s1 = 8'd0;
      s2 = 8'd0;
      s1 = s1 + header_byte;          s2 = s2 + s1;
      s1 = s1 + dest_address;         s2 = s2 + s1;
      s1 = s1 + beat.function_code;   s2 = s2 + s1;
      s1 = s1 + beat.payload_length;  s2 = s2 + s1;
      left_base = (beat.payload_length == 8'd0) ? 8'd1 : beat.payload_length;
    end else begin
      s1        = cur.byte_sum;
      s2        = cur.sum_of_sums;
      left_base = cur.bytes_left;
    end

    // Count the payload byte itself
    s1 = s1 + beat.payload_byte;
    s2 = s2 + s1;
    left_new   = left_base - 8'd1;
    res.closes = active && (left_new == 8'd0);

    if (!active) begin
      // Stray byte outside a frame: drop it, keep state
      res.state = cur;
    end else begin
      if (beat.frame_start) begin
        res.bytes[0] = header_byte;
        res.bytes[1] = dest_address;
        res.bytes[2] = beat.function_code;
        res.bytes[3] = beat.payload_length;
        res.bytes[4] = beat.payload_byte;
        res.bytes[5] = s1;
        res.bytes[6] = s2;
        res.cnt      = res.closes ? CNT_W'(7) : CNT_W'(5);
      end else begin
        res.bytes[0] = beat.payload_byte;
        res.bytes[1] = s1;
        res.bytes[2] = s2;
        res.cnt      = res.closes ? CNT_W'(3) : CNT_W'(1);
      end
      res.state.bytes_left  = left_new;
      res.state.byte_sum    = res.closes ? 8'd0 : s1;
      res.state.sum_of_sums = res.closes ? 8'd0 : s2;
    end
  end

endmodule

[rtl/core/telemetry_frame_checksum_builder.sv]
// Telemetry framer: each payload beat is taken into an input register and
// turned in one pass into the bytes it causes (header, address, function code
// and length ahead of a frame's first byte; the two modulo-256 checksum bytes
// after its last), which load an output buffer that sends one byte per cycle
// while out_stall is low. A payload beat inside a frame yields one byte, so
// payload flows at one byte per cycle unless stalled; a start beat yields five
// bytes, or seven if it also closes the frame, and a closing beat three. The
// output buffer drain sets the rate at which beats are taken. A new beat is
// taken while the last buffered byte is leaving, and a beat passes the hold
// register and then the output buffer before its first byte is on out_byte.
// Registers sit at byte addresses 0 (header byte, reset 0xAA) and 4
// (destination address, reset 0xFF); write them only while the block is idle.
module telemetry_frame_checksum_builder (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tfcb_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // payload in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_payload_byte,
  input  logic                          in_frame_start,
  input  logic [7:0]                    in_function_code,
  input  logic [7:0]                    in_payload_length,
  // framed bytes out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_frame_end
);
  import tfcb_pkg::*;

  byte_t                     header_r;
  byte_t                     dest_r;
  frame_state_t              state_r;
  logic                      hold_v_r;
  in_beat_t                  hold_r;
  logic [MAX_BYTES-1:0][7:0] buf_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      close_r;

  frame_res_t                res;
  logic                      cfg_wr;
  reg_sel_t                  sel;
  logic                      in_take;
  logic                      out_take;
  logic                      buf_free;
  logic                      load;

  // Register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign sel    = reg_sel_t'(paddr[2]);

  always_comb begin
    unique case (sel)
      REG_HEADER: prdata = {24'd0, header_r};
      REG_DEST:   prdata = {24'd0, dest_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      dest_r   <= DEST_RST;
    end else if (cfg_wr) begin
      unique case (sel)
        REG_HEADER: header_r <= pwdata[7:0];
        REG_DEST:   dest_r   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  // Handshakes: load the buffer once it empties this cycle
  assign out_take = out_valid && !out_stall;
  assign buf_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_take);
  assign load     = hold_v_r && buf_free;
  assign in_stall = hold_v_r && !load;
  assign in_take  = in_valid && !in_stall;

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_take) begin
      hold_v_r <= 1'b1;
    end else if (load) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r.payload_byte   <= in_payload_byte;
      hold_r.frame_start    <= in_frame_start;
      hold_r.function_code  <= in_function_code;
      hold_r.payload_length <= in_payload_length;
    end
  end

  tfcb_frame_calc u_calc (
    .beat         (hold_r),
    .cur          (state_r),
    .header_byte  (header_r),
    .dest_address (dest_r),
    .res          (res)
  );

  // Advance frame state on each load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (load) begin
      state_r <= res.state;
    end
  end

  // Output buffer: load a beat's bytes, shift one out per taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      close_r <= 1'b0;
    end else if (load) begin
      cnt_r   <= res.cnt;
      close_r <= res.closes;
    end else if (out_take) begin
      cnt_r   <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= res.bytes;
    end else if (out_take) begin
      buf_r <= buf_r >> 8;
    end
  end

  assign out_valid     = (cnt_r != '0);
  assign out_byte      = buf_r[0];
  assign out_frame_end = close_r && (cnt_r == CNT_W'(1));

endmodule

[rtl/core/tfcb_checker.sv]
module tfcb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [tfcb_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [7:0]                  out_byte,
  input logic                        out_frame_end
);

  // Reset empties the output side
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // End-of-frame marker only rides on a live beat
  a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_end |-> out_valid)
    else $error("frame end without valid beat");

  // Stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_frame_end))
    else $error("stalled output beat changed");

  // Written register reads back on the next cycle
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2]))
    |-> prdata == {24'd0, $past(pwdata[7:0])})
    else $error("register readback mismatch");

endmodule

bind telemetry_frame_checksum_builder tfcb_checker u_tfcb_checker (.*);

[tb/sv/telemetry_frame_checksum_builder_tb.sv]
`timescale 1ns / 100ps

module telemetry_frame_checksum_builder_tb;
  import tfcb_pkg::*;

  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 35;
  localparam int NUM_PHASES   = 5;
  localparam int NUM_ROWS     = 19;
  localparam logic [3:0] PREDICTED = 4'hF;

  typedef struct packed {
    byte_t value;
    logic  ends;
  } framed_byte_t;

  // One directed beat; fixed_n other than PREDICTED means the bytes are typed in
  typedef struct packed {
    byte_t       data;
    logic        start;
    byte_t       code;
    byte_t       len;
    logic [3:0]  fixed_n;
    logic [55:0] fixed;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [7:0] in_payload_byte, in_function_code, in_payload_length;
  logic in_frame_start;
  logic out_valid, out_stall;
  logic [7:0] out_byte;
  logic out_frame_end;

  // Predictor copy of the framer state and registers
  byte_t hdr_reg, dest_reg;
  byte_t run_sum, run_sum2, bytes_left;

  framed_byte_t framed_q[$];
  framed_byte_t beat_bytes[$];
  int fails = 0;
  int items_done = 0;
  int gap_pct = 30;
  int stall_pct = 30;
  int hold_asks = 0;

  telemetry_frame_checksum_builder dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_payload_byte(in_payload_byte), .in_frame_start(in_frame_start),
    .in_function_code(in_function_code), .in_payload_length(in_payload_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_frame_end(out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Append one framed byte, folding it into both sums when counted
  task automatic push_byte(input byte_t b, input logic last, input logic count);
    if (count) begin
      run_sum  = run_sum + b;
      run_sum2 = run_sum2 + run_sum;
    end
    beat_bytes.push_back('{value: b, ends: last});
  endtask

  // Work out the framed bytes one payload beat causes
  task automatic build_frame_bytes(input byte_t d, input logic s, input byte_t c,
                                   input byte_t l, output bit taken);
    beat_bytes.delete();
    taken = 1'b1;
    if (s) begin
      run_sum  = 8'h00;
      run_sum2 = 8'h00;
      push_byte(hdr_reg, 1'b0, 1'b1);
      push_byte(dest_reg, 1'b0, 1'b1);
      push_byte(c, 1'b0, 1'b1);
      push_byte(l, 1'b0, 1'b1);
      bytes_left = (l == 8'h00) ? 8'h01 : l;
    end else if (bytes_left == 8'h00) begin
      taken = 1'b0;
      return;
    end
    push_byte(d, 1'b0, 1'b1);
    bytes_left = bytes_left - 8'h01;
    // close the frame: both sums go out uncounted, then clear
    if (bytes_left == 8'h00) begin
      push_byte(run_sum, 1'b0, 1'b0);
      push_byte(run_sum2, 1'b1, 1'b0);
      run_sum  = 8'h00;
      run_sum2 = 8'h00;
    end
  endtask

  // Offer one beat, with an occasional gap ahead of it, and hold until taken
  task automatic offer_beat(input byte_t d, input logic s, input byte_t c, input byte_t l);
    bit go;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_payload_byte   <= d;
    in_frame_start    <= s;
    in_function_code  <= c;
    in_payload_length <= l;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
  endtask

  task automatic send_beat(input byte_t d, input logic s, input byte_t c, input byte_t l);
    bit taken;
    offer_beat(d, s, c, l);
    build_frame_bytes(d, s, c, l, taken);
    foreach (beat_bytes[k]) framed_q.push_back(beat_bytes[k]);
    if (taken) items_done++;
  endtask

  // Mostly whole frames with random content; some cut short, some stray beats
  task automatic send_random_frame(input int max_len);
    int kind;
    int len;
    int follow;
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_beat(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                8'($urandom_range(255)));
      return;
    end
    if (kind < 20) begin
      len = $urandom_range(20, 2);
      follow = $urandom_range(len - 2, 0);
    end else begin
      kind = $urandom_range(99);
      if (kind < 8)       len = 0;
      else if (kind < 70) len = $urandom_range(6, 1);
      else if (kind < 95) len = $urandom_range(24, 7);
      else                len = $urandom_range(max_len, 25);
      follow = (len == 0) ? 0 : len - 1;
    end
    send_beat(8'($urandom_range(255)), 1'b1, 8'($urandom_range(255)), len[7:0]);
    repeat (follow)
      send_beat(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                8'($urandom_range(255)));
  endtask

  // Register write: setup beat then access beat
  task automatic cfg_write(input reg_sel_t sel, input byte_t v);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(sel) << 2;
    pwdata  <= {24'h000000, v};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (sel)
      REG_HEADER: hdr_reg = v;
      REG_DEST:   dest_reg = v;
      default: ;
    endcase
  endtask

  // Hold the sender until every framed byte is out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver stall: random, plus long hold-offs on request
  initial begin
    int left;
    int seen;
    left = 0;
    seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != seen) begin
        seen = hold_asks;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check each output beat against the oldest expected byte
  always @(negedge clk) begin : out_check
    framed_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (framed_q.size() == 0) begin
        $error("unexpected out_byte 0x%02h (frame_end %0b)", out_byte, out_frame_end);
        fails++;
      end else begin
        want = framed_q.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.value, out_byte);
          fails++;
        end
        if (out_frame_end !== want.ends) begin
          $error("out_frame_end: expected %0b, got %0b", want.ends, out_frame_end);
          fails++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [NUM_ROWS];
    dir_row_t row;
    bit taken;
    int spin;
    byte_t hdr_set [NUM_PHASES];
    byte_t dest_set [NUM_PHASES];

    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_valid          <= 1'b0;
    in_payload_byte   <= '0;
    in_frame_start    <= 1'b0;
    in_function_code  <= '0;
    in_payload_length <= '0;
    hdr_reg    = HEADER_RST;
    dest_reg   = DEST_RST;
    run_sum    = 8'h00;
    run_sum2   = 8'h00;
    bytes_left = 8'h00;

    // Directed beats; typed rows are read straight off the framing rules
    dir_rows[0]  = '{8'h00, 1'b1, 8'h00, 8'h01, 4'd7, 56'hAA_FF_00_01_00_AA_50};
    // stray beat with no frame open: nothing comes out
    dir_rows[1]  = '{8'h5A, 1'b0, 8'hC3, 8'h07, 4'd0, 56'h0};
    dir_rows[2]  = '{8'hFF, 1'b1, 8'hFF, 8'h01, 4'd7, 56'hAA_FF_FF_01_FF_A8_4C};
    // zero length closes after the start beat
    dir_rows[3]  = '{8'h01, 1'b1, 8'h80, 8'h00, PREDICTED, 56'h0};
    dir_rows[4]  = '{8'h12, 1'b1, 8'h01, 8'h03, PREDICTED, 56'h0};
    dir_rows[5]  = '{8'h34, 1'b0, 8'h00, 8'h00, PREDICTED, 56'h0};
    dir_rows[6]  = '{8'h56, 1'b0, 8'h00, 8'h00, PREDICTED, 56'h0};
    // restart in mid-frame drops the open frame
    dir_rows[7]  = '{8'hAA, 1'b1, 8'h7F, 8'h05, PREDICTED, 56'h0};
    dir_rows[8]  = '{8'h55, 1'b0, 8'hFF, 8'hFF, PREDICTED, 56'h0};
    dir_rows[9]  = '{8'h80, 1'b1, 8'h03, 8'h02, PREDICTED, 56'h0};
    dir_rows[10] = '{8'h0D, 1'b0, 8'h00, 8'h00, PREDICTED, 56'h0};
    // longest length opened, then cut by a restart
    dir_rows[11] = '{8'h00, 1'b1, 8'hFE, 8'hFF, PREDICTED, 56'h0};
    dir_rows[12] = '{8'hFF, 1'b0, 8'h00, 8'h00, PREDICTED, 56'h0};
    dir_rows[13] = '{8'h00, 1'b0, 8'h00, 8'h00, PREDICTED, 56'h0};
    dir_rows[14] = '{8'hC3, 1'b1, 8'h0D, 8'h02, PREDICTED, 56'h0};
    dir_rows[15] = '{8'h3C, 1'b0, 8'h00, 8'h00, PREDICTED, 56'h0};
    dir_rows[16] = '{8'hFF, 1'b0, 8'hFF, 8'hFF, PREDICTED, 56'h0};
    dir_rows[17] = '{8'h7E, 1'b1, 8'h55, 8'h02, PREDICTED, 56'h0};
    dir_rows[18] = '{8'h81, 1'b0, 8'h00, 8'h00, PREDICTED, 56'h0};

    hdr_set  = '{8'h00, 8'hFF, 8'h00, 8'h55, HEADER_RST};
    dest_set = '{8'h00, 8'hFF, 8'h00, 8'hAA, DEST_RST};
    hdr_set[2]  = 8'($urandom_range(255));
    dest_set[2] = 8'($urandom_range(255));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset register values
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = dir_rows[r];
      offer_beat(row.data, row.start, row.code, row.len);
      build_frame_bytes(row.data, row.start, row.code, row.len, taken);
      if (row.fixed_n == PREDICTED) begin
        foreach (beat_bytes[k]) framed_q.push_back(beat_bytes[k]);
      end else begin
        for (int k = 0; k < row.fixed_n; k++)
          framed_q.push_back('{value: row.fixed[55 - 8*k -: 8],
                                ends: (k == row.fixed_n - 1)});
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      cfg_write(REG_HEADER, hdr_set[p]);
      cfg_write(REG_DEST, dest_set[p]);
      gap_pct   = (p == 2) ? 0 : 30;
      stall_pct = (p == 2) ? 0 : 30;
      // long receiver hold-off while a long frame keeps coming
      if (p == 3) begin
        hold_asks <= hold_asks + 1;
        send_beat(8'($urandom_range(255)), 1'b1, 8'($urandom_range(255)), 8'd40);
        repeat (39)
          send_beat(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      end
      items_done = 0;
      while (items_done < ITEMS_PER_PHASE)
        send_random_frame(64);
    end

    // Drain and finish
    in_valid <= 1'b0;
    for (spin = 0; spin < 20000 && framed_q.size() != 0; spin++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (framed_q.size() != 0) begin
      $error("%0d framed bytes never came out", framed_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
